FILE: hw/rtl/qualified_block_average_core_macros.svh
// Assertion macros used by the checker file.
`ifndef QUALIFIED_BLOCK_AVERAGE_CORE_MACROS_SVH
`define QUALIFIED_BLOCK_AVERAGE_CORE_MACROS_SVH

// Checked outside reset only.
`define QBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Checked at every edge, reset included.
`define QBA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

FILE: hw/rtl/qba_pkg.sv
package qba_pkg;

  localparam int SAMPLES_PER_BLOCK = 4;   // power of two, 2 to 16
  localparam int CNT_W             = $clog2(SAMPLES_PER_BLOCK);

  localparam int RAW_W    = 12;
  localparam int LOW_W    = 12;
  localparam int HIGH_W   = 13;
  localparam int DIV_W    = 8;
  localparam int SAMPLE_W = 13;
  localparam int AVG_W    = 13;
  localparam int SUM_W    = SAMPLE_W + CNT_W;
  localparam int DEV_W    = SUM_W + 1;
  localparam int PROD_W   = DEV_W + DIV_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAB_DIV   = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [LOW_W-1:0]  low_limit;
    logic signed [HIGH_W-1:0] high_limit;
    logic [DIV_W-1:0]         stability_divisor;
  } cfg_t;

  // One full block handed from front to back.
  typedef struct packed {
    sample_t [SAMPLES_PER_BLOCK-1:0] samples;
    logic signed [SUM_W-1:0]         sum;
  } blk_t;

endpackage

FILE: hw/rtl/qba_front.sv
module qba_front import qba_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [RAW_W-1:0] in_raw_signal,
  input  logic signed [RAW_W-1:0] in_raw_therm,
  input  logic                    q_full,
  output logic                    q_push,
  output blk_t                    q_blk
);

  sample_t                 store_r [SAMPLES_PER_BLOCK-1];
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  sample_t                 sig_n, thm_n, low_ext, high_ext;
  logic                    qual, acc, last;
  logic signed [SUM_W-1:0] sum_add;

  assign sig_n    = -SAMPLE_W'(in_raw_signal);
  assign thm_n    = -SAMPLE_W'(in_raw_therm);
  assign low_ext  = SAMPLE_W'($signed(cfg.low_limit));
  assign high_ext = $signed(cfg.high_limit);

  assign qual = (sig_n > low_ext) && (sig_n < high_ext) &&
                (thm_n > low_ext) && (thm_n < high_ext);

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall && qual;
  assign last     = (fill_r == CNT_W'(SAMPLES_PER_BLOCK - 1));
  assign sum_add  = sum_r + SUM_W'(sig_n);
  assign q_push   = acc && last;

  always_comb begin
    for (int i = 0; i < SAMPLES_PER_BLOCK - 1; i++) begin
      q_blk.samples[i] = store_r[i];
    end
    q_blk.samples[SAMPLES_PER_BLOCK-1] = sig_n;
    q_blk.sum = sum_add;
  end

  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (acc) begin
      if (last) begin
        fill_nxt = '0;
        sum_nxt  = '0;
      end else begin
        fill_nxt = fill_r + 1'b1;
        sum_nxt  = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !last) begin
      store_r[fill_r] <= sig_n;
    end
  end

endmodule

FILE: hw/rtl/qba_fifo.sv
module qba_fifo import qba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  blk_t push_blk,
  output logic full,
  input  logic pop,
  output logic empty,
  output blk_t pop_blk
);

  blk_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_blk = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_blk;
    end
  end

endmodule

FILE: hw/rtl/qba_back.sv
module qba_back import qba_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    q_empty,
  input  blk_t                    q_blk,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [AVG_W-1:0] out_block_average
);

  // stage 1: deviations, magnitude, average
  logic                    s1_vld_r;
  logic [DEV_W-1:0]        dev_r [SAMPLES_PER_BLOCK];
  logic [SUM_W-1:0]        mag_r;
  logic signed [AVG_W-1:0] avg_r;

  logic [DEV_W-1:0]        dev_c [SAMPLES_PER_BLOCK];
  logic [SUM_W-1:0]        mag_c;
  logic signed [AVG_W-1:0] avg_c;

  // output stage
  logic                    out_vld_r;
  logic signed [AVG_W-1:0] out_avg_r;

  logic s1_free, s2_free, ok;

  always_comb begin
    logic signed [SUM_W-1:0] ns;
    logic signed [DEV_W-1:0] diff;
    logic signed [SUM_W-1:0] biased;
    for (int i = 0; i < SAMPLES_PER_BLOCK; i++) begin
      ns   = $signed({q_blk.samples[i], {CNT_W{1'b0}}});
      diff = DEV_W'(q_blk.sum) - DEV_W'(ns);
      dev_c[i] = diff[DEV_W-1] ? DEV_W'(-diff) : DEV_W'(diff);
    end
    mag_c  = q_blk.sum[SUM_W-1] ? SUM_W'(-q_blk.sum) : SUM_W'(q_blk.sum);
    biased = q_blk.sum[SUM_W-1] ? q_blk.sum + SUM_W'(SAMPLES_PER_BLOCK - 1) : q_blk.sum;
    avg_c  = biased[SUM_W-1:CNT_W];
  end

  always_comb begin
    logic [PROD_W-1:0] prod;
    ok = 1'b1;
    for (int i = 0; i < SAMPLES_PER_BLOCK; i++) begin
      prod = PROD_W'(cfg.stability_divisor) * PROD_W'(dev_r[i]);
      if (prod > PROD_W'(mag_r)) begin
        ok = 1'b0;
      end
    end
  end

  assign s2_free = !out_vld_r || !out_stall;
  assign s1_free = !s1_vld_r || s2_free;
  assign q_pop   = !q_empty && s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_r <= !q_empty;
      end
      if (s2_free) begin
        out_vld_r <= s1_vld_r && ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dev_r <= dev_c;
      mag_r <= mag_c;
      avg_r <= avg_c;
    end
    if (s2_free && s1_vld_r && ok) begin
      out_avg_r <= avg_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_block_average = out_avg_r;

endmodule

FILE: hw/rtl/qualified_block_average_core.sv
// Stability-checked block averager. Each transaction carries a signal and a
// thermistor converter result; both are negated, and the pair is kept only if
// both lie strictly between low_limit and high_limit. Kept signal samples are
// gathered in blocks of four; a full block yields one result, sum/4 truncated
// toward zero, when stability_divisor*|sum-4*s| <= |sum| holds for each sample,
// and is dropped otherwise. One pair is taken every cycle while in_stall is low;
// a full block passes through the queue, stage 1 and the output register before
// its result is valid. Full blocks wait in a four-entry queue; in_stall rises
// only when that queue is full while the output is held by out_stall. Registers
// at index 0 (low_limit), 1 (high_limit) and 2 (stability_divisor) must be
// written only while idle, a duty left to the user; cfg_ready is always high.
module qualified_block_average_core import qba_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [RAW_W-1:0] in_raw_signal,
  input  logic signed [RAW_W-1:0] in_raw_therm,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [AVG_W-1:0] out_block_average
);

  cfg_t cfg_r;
  logic q_full, q_push, q_pop, q_empty;
  blk_t push_blk, pop_blk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit         <= -LOW_W'(30);
      cfg_r.high_limit        <= HIGH_W'(2060);
      cfg_r.stability_divisor <= DIV_W'(20);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_LIMIT:  cfg_r.low_limit         <= cfg_data[LOW_W-1:0];
        REG_HIGH_LIMIT: cfg_r.high_limit        <= cfg_data[HIGH_W-1:0];
        REG_STAB_DIV:   cfg_r.stability_divisor <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  qba_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_signal (in_raw_signal),
    .in_raw_therm  (in_raw_therm),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_blk         (push_blk)
  );

  qba_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_blk (push_blk),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_blk  (pop_blk)
  );

  qba_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_blk             (pop_blk),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_block_average (out_block_average)
  );

endmodule

FILE: hw/rtl/qba_checker.sv
`include "qualified_block_average_core_macros.svh"

module qba_checker import qba_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [AVG_W-1:0] out_block_average
);

  // reset empties the pipeline and the block queue
  `QBA_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid && !in_stall)

  // the queue only fills through an accepted transaction
  `QBA_ASSERT(a_stall_after_push, clk, rst_n, $rose(in_stall) |-> $past(in_valid && !in_stall))

  // a held result stays
  `QBA_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_block_average))

endmodule

bind qualified_block_average_core qba_checker u_qba_checker (.*);
